@@ sv/cmap_pkg.sv @@
package cmap_pkg;

   localparam int SMP_W      = 16;
   localparam int IDX_W      = 10;
   localparam int DEN_W      = 16;
   localparam int NUM_W      = DEN_W + IDX_W;
   localparam int NUMS_W     = NUM_W + 1;
   localparam int SPAN_W     = SMP_W + 1;
   localparam int DIV_STAGES = IDX_W;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int SEG_W      = 9;
   localparam int PROD_W     = SEG_W + CH_W;
   localparam int RED_W      = PROD_W - 4;
   localparam int RECIP_W    = 13;
   localparam int RPROD_W    = RED_W + RECIP_W;
   localparam int CSR_IDX_W  = 2;

   localparam int SCALE_TOP  = 1000;
   localparam int PT_MID_LO  = 400;
   localparam int PT_MID_HI  = 600;

   // floor(x / 25) == (x * RECIP) >> RECIP_SH for every x below 43690
   localparam int RECIP      = 5243;
   localparam int RECIP_SH   = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_MODE = 2'd2;

   typedef enum logic [1:0] {
      SEG_LOW  = 2'd0,
      SEG_MID  = 2'd1,
      SEG_HIGH = 2'd2
   } seg_type;

   // entry, channel (0 red, 1 green, 2 blue)
   localparam logic [3:0][NUM_CH-1:0][CH_W-1:0] COLOR_TBL = {
      {8'd0,   8'd0,   8'd200},
      {8'd0,   8'd150, 8'd150},
      {8'd150, 8'd0,   8'd0},
      {8'd200, 8'd200, 8'd200}
   };

   typedef struct packed {
      logic             fixed;
      logic [IDX_W-1:0] fidx;
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [IDX_W-1:0] quo;
   } div_item_type;

endpackage

@@ sv/cmap_prep.sv @@
module cmap_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic signed [cmap_pkg::SMP_W-1:0] sample,
   input  logic signed [cmap_pkg::SMP_W-1:0] range_min,
   input  logic signed [cmap_pkg::SMP_W-1:0] range_max,
   input  logic                              direct_mode,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output cmap_pkg::div_item_type            dn_item
);
   import cmap_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     v1_in, v2_in, v3_in;
   logic                     en1, en2, en3;

   logic                     dir1_ff, dir2_ff;
   logic [IDX_W-1:0]         didx1_ff, didx2_ff;
   logic signed [SPAN_W-1:0] diff1_ff, span1_ff, span2_ff;
   logic signed [NUMS_W-1:0] num2_ff;
   div_item_type             item3_ff;

   logic [IDX_W-1:0]         didx_in;
   logic signed [SPAN_W-1:0] diff_in, span_in;
   logic signed [NUMS_W-1:0] num_in;
   logic [NUMS_W-1:0]        num_mag;
   logic [SPAN_W-1:0]        span_mag;
   div_item_type             item_in;

   assign en3      = !v3_ff || dn_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   assign v1_in = en1 ? up_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // direct index, clamped to the table
   always_comb begin
      priority if (sample[SMP_W-1]) begin
         didx_in = '0;
      end else if (sample[SMP_W-2:0] > (SMP_W-1)'(SCALE_TOP)) begin
         didx_in = IDX_W'(SCALE_TOP);
      end else begin
         didx_in = sample[IDX_W-1:0];
      end
   end

   assign diff_in = $signed({sample[SMP_W-1], sample} - {range_min[SMP_W-1], range_min});
   assign span_in = $signed({range_max[SMP_W-1], range_max} - {range_min[SMP_W-1], range_min});
   assign num_in  = NUMS_W'(diff1_ff) * NUMS_W'(SCALE_TOP);

   assign num_mag  = num2_ff[NUMS_W-1] ? NUMS_W'(-num2_ff) : NUMS_W'(num2_ff);
   assign span_mag = span2_ff[SPAN_W-1] ? SPAN_W'(-span2_ff) : SPAN_W'(span2_ff);

   // direct mode passes the clamped index; otherwise opposite signs or a zero range give index 0
   always_comb begin
      item_in.fixed = dir2_ff || (span2_ff == '0) || (num2_ff[NUMS_W-1] != span2_ff[SPAN_W-1]);
      item_in.fidx  = dir2_ff ? didx2_ff : '0;
      item_in.rem   = num_mag[NUM_W-1:0];
      item_in.den   = span_mag[DEN_W-1:0];
      item_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dir1_ff  <= direct_mode;
         didx1_ff <= didx_in;
         diff1_ff <= diff_in;
         span1_ff <= span_in;
      end
      if (en2) begin
         dir2_ff  <= dir1_ff;
         didx2_ff <= didx1_ff;
         num2_ff  <= num_in;
         span2_ff <= span1_ff;
      end
      if (en3) begin
         item3_ff <= item_in;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_item  = item3_ff;

endmodule

@@ sv/cmap_div.sv @@
module cmap_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cmap_pkg::div_item_type up_item,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output cmap_pkg::div_item_type dn_item
);
   import cmap_pkg::*;

   // stage 0 checks for a quotient too wide for IDX_W bits, stage k settles quotient bit DIV_STAGES-k
   logic         [DIV_STAGES:0] v_ff, v_in, en;
   div_item_type                stg_ff [DIV_STAGES+1];
   div_item_type                stg_in [DIV_STAGES+1];

   always_comb begin
      en[DIV_STAGES] = !v_ff[DIV_STAGES] || dn_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? up_valid : v_ff[0];
      for (int k = 1; k <= DIV_STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   assign up_ready = en[0];

   always_comb begin
      logic [NUM_W-1:0] sh;
      stg_in[0] = up_item;
      if (!up_item.fixed && (up_item.rem >= {up_item.den, IDX_W'(0)})) begin
         stg_in[0].fixed = 1'b1;
         stg_in[0].fidx  = IDX_W'(SCALE_TOP);
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         stg_in[k] = stg_ff[k-1];
         sh        = NUM_W'(stg_ff[k-1].den) << (DIV_STAGES - k);
         if (stg_ff[k-1].rem >= sh) begin
            stg_in[k].rem                 = stg_ff[k-1].rem - sh;
            stg_in[k].quo[DIV_STAGES - k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign dn_valid = v_ff[DIV_STAGES];
   assign dn_item  = stg_ff[DIV_STAGES];

endmodule

@@ sv/cmap_interp.sv @@
module cmap_interp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  cmap_pkg::div_item_type       up_item,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic [cmap_pkg::CH_W-1:0]    red,
   output logic [cmap_pkg::CH_W-1:0]    green,
   output logic [cmap_pkg::CH_W-1:0]    blue
);
   import cmap_pkg::*;

   logic                                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                                 v1_in, v2_in, v3_in, v4_in;
   logic                                 en1, en2, en3, en4;

   seg_type                              seg1_ff, seg2_ff;
   logic [SEG_W-1:0]                     a1_ff, b1_ff;
   logic [NUM_CH-1:0][PROD_W-1:0]        pa2_ff, pb2_ff;
   logic [NUM_CH-1:0][RED_W-1:0]         x3_ff;
   logic [NUM_CH-1:0][CH_W-1:0]          rgb4_ff;

   logic [IDX_W-1:0]                     idx;
   seg_type                              seg_in;
   logic [IDX_W-1:0]                     a_in, b_in;
   logic [1:0]                           ent_lo, ent_hi;
   logic [NUM_CH-1:0][PROD_W-1:0]        pa_in, pb_in;
   logic [NUM_CH-1:0][RED_W-1:0]         x_in;
   logic [NUM_CH-1:0][CH_W-1:0]          rgb_in;
   logic [PROD_W-1:0]                    sum;
   logic [RPROD_W-1:0]                   rprod;

   assign en4      = !v4_ff || dn_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   assign v1_in = en1 ? up_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_comb begin
      priority if (up_item.fixed) begin
         idx = up_item.fidx;
      end else if (up_item.quo > IDX_W'(SCALE_TOP)) begin
         idx = IDX_W'(SCALE_TOP);
      end else begin
         idx = up_item.quo;
      end
      priority if (idx > IDX_W'(PT_MID_HI)) begin
         seg_in = SEG_HIGH;
         a_in   = IDX_W'(SCALE_TOP) - idx;
         b_in   = idx - IDX_W'(PT_MID_HI);
      end else if (idx > IDX_W'(PT_MID_LO)) begin
         seg_in = SEG_MID;
         a_in   = IDX_W'(PT_MID_HI) - idx;
         b_in   = idx - IDX_W'(PT_MID_LO);
      end else begin
         seg_in = SEG_LOW;
         a_in   = IDX_W'(PT_MID_LO) - idx;
         b_in   = idx;
      end
   end

   assign ent_lo = 2'(seg1_ff);
   assign ent_hi = ent_lo + 2'd1;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         pa_in[ch] = PROD_W'(a1_ff) * PROD_W'(COLOR_TBL[ent_lo][ch]);
         pb_in[ch] = PROD_W'(b1_ff) * PROD_W'(COLOR_TBL[ent_hi][ch]);
      end
   end

   // segment widths are 16*25 or 8*25: shift first, then divide by 25
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = pa2_ff[ch] + pb2_ff[ch];
         unique case (seg2_ff)
            SEG_MID: x_in[ch] = RED_W'(sum >> 3);
            default: x_in[ch] = RED_W'(sum >> 4);
         endcase
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rprod      = RPROD_W'(x3_ff[ch]) * RPROD_W'(RECIP);
         rgb_in[ch] = rprod[RECIP_SH +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         seg1_ff <= seg_in;
         a1_ff   <= a_in[SEG_W-1:0];
         b1_ff   <= b_in[SEG_W-1:0];
      end
      if (en2) begin
         seg2_ff <= seg1_ff;
         pa2_ff  <= pa_in;
         pb2_ff  <= pb_in;
      end
      if (en3) begin
         x3_ff <= x_in;
      end
      if (en4) begin
         rgb4_ff <= rgb_in;
      end
   end

   assign dn_valid = v4_ff;
   assign red      = rgb4_ff[0];
   assign green    = rgb4_ff[1];
   assign blue     = rgb4_ff[2];

endmodule

@@ sv/value_to_color_map_top.sv @@
// pipeline: 18 stages (3 scaling, 11 divider, 4 color) from item acceptance to rsp_valid
// throughput: one item per cycle unless stalled; the divider settles one quotient bit per stage
// a stall holds each stage only while the stage after it is full
// reset: synchronous, active high; clears all valid bits and sets range 0..1000, direct off
module value_to_color_map_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [cmap_pkg::SMP_W-1:0]     req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cmap_pkg::CH_W-1:0]             rsp_red,
   output logic [cmap_pkg::CH_W-1:0]             rsp_green,
   output logic [cmap_pkg::CH_W-1:0]             rsp_blue,
   input  logic                                  csr_wr_en,
   input  logic [cmap_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cmap_pkg::SMP_W-1:0]            csr_wdata
);
   import cmap_pkg::*;

   logic signed [SMP_W-1:0] range_min_ff, range_min_in;
   logic signed [SMP_W-1:0] range_max_ff, range_max_in;
   logic                    direct_ff, direct_in;

   logic                    div_up_valid, div_up_ready;
   logic                    div_dn_valid, div_dn_ready;
   div_item_type            div_up_item, div_dn_item;

   always_comb begin
      range_min_in = range_min_ff;
      range_max_in = range_max_ff;
      direct_in    = direct_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RANGE_MIN:   range_min_in = $signed(csr_wdata);
            CSR_RANGE_MAX:   range_max_in = $signed(csr_wdata);
            CSR_DIRECT_MODE: direct_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= '0;
         range_max_ff <= SMP_W'(SCALE_TOP);
         direct_ff    <= 1'b0;
      end else begin
         range_min_ff <= range_min_in;
         range_max_ff <= range_max_in;
         direct_ff    <= direct_in;
      end
   end

   cmap_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_valid),
      .up_ready    (req_ready),
      .sample      (req_sample),
      .range_min   (range_min_ff),
      .range_max   (range_max_ff),
      .direct_mode (direct_ff),
      .dn_valid    (div_up_valid),
      .dn_ready    (div_up_ready),
      .dn_item     (div_up_item)
   );

   cmap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (div_up_valid),
      .up_ready (div_up_ready),
      .up_item  (div_up_item),
      .dn_valid (div_dn_valid),
      .dn_ready (div_dn_ready),
      .dn_item  (div_dn_item)
   );

   cmap_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .up_valid (div_dn_valid),
      .up_ready (div_dn_ready),
      .up_item  (div_dn_item),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .red      (rsp_red),
      .green    (rsp_green),
      .blue     (rsp_blue)
   );

`ifndef NO_ASSERTIONS
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      div_dn_valid && !div_dn_item.fixed |-> div_dn_item.rem < NUM_W'(div_dn_item.den))
      else $error("divider remainder not below divisor");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline stalls although the result side is ready");

   a_color_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red <= CH_W'(200) && rsp_green <= CH_W'(200) && rsp_blue <= CH_W'(200))
      else $error("interpolated color beyond table range");
`endif

endmodule

@@ bench/value_to_color_map_checker.sv @@
`timescale 1ns / 1ps
module value_to_color_map_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [cmap_pkg::SMP_W-1:0] req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [cmap_pkg::CH_W-1:0]         rsp_red,
   input  logic [cmap_pkg::CH_W-1:0]         rsp_green,
   input  logic [cmap_pkg::CH_W-1:0]         rsp_blue,
   input  logic                              csr_wr_en,
   input  logic [cmap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cmap_pkg::SMP_W-1:0]        csr_wdata,
   output int                                mismatch_count,
   output int                                waiting_items
);
   import cmap_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   localparam rgb_type PAL_START      = {8'd200, 8'd200, 8'd200};
   localparam rgb_type PAL_LOW_END    = {8'd0,   8'd0,   8'd150};
   localparam rgb_type PAL_HIGH_START = {8'd150, 8'd150, 8'd0};
   localparam rgb_type PAL_END        = {8'd200, 8'd0,   8'd0};

   logic signed [SMP_W-1:0] map_lo;
   logic signed [SMP_W-1:0] map_hi;
   logic                    direct_on;
   rgb_type                 color_due[$];

   function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] c_lo,
                                             input logic [CH_W-1:0] c_hi,
                                             input longint pos,
                                             input longint lo,
                                             input longint hi);
      longint num;
      num = (hi - pos) * longint'(c_lo) + (pos - lo) * longint'(c_hi);
      return CH_W'(num / (hi - lo));
   endfunction

   function automatic rgb_type expected_color(input logic signed [SMP_W-1:0] smp);
      longint  span;
      longint  pos;
      longint  lo;
      longint  hi;
      seg_type seg;
      rgb_type c_lo;
      rgb_type c_hi;
      rgb_type c;
      if (direct_on) begin
         pos = longint'(smp);
      end else begin
         span = longint'(map_hi) - longint'(map_lo);
         // zero range maps everything to the first table entry
         if (span == 0) pos = 0;
         else pos = (longint'(smp) - longint'(map_lo)) * SCALE_TOP / span;
      end
      if (pos < 0) pos = 0;
      if (pos > SCALE_TOP) pos = SCALE_TOP;
      if (pos <= PT_MID_LO) seg = SEG_LOW;
      else if (pos <= PT_MID_HI) seg = SEG_MID;
      else seg = SEG_HIGH;
      case (seg)
         SEG_LOW: begin
            lo = 0; hi = PT_MID_LO; c_lo = PAL_START; c_hi = PAL_LOW_END;
         end
         SEG_MID: begin
            lo = PT_MID_LO; hi = PT_MID_HI; c_lo = PAL_LOW_END; c_hi = PAL_HIGH_START;
         end
         default: begin
            lo = PT_MID_HI; hi = SCALE_TOP; c_lo = PAL_HIGH_START; c_hi = PAL_END;
         end
      endcase
      c.red   = blend(c_lo.red,   c_hi.red,   pos, lo, hi);
      c.green = blend(c_lo.green, c_hi.green, pos, lo, hi);
      c.blue  = blend(c_lo.blue,  c_hi.blue,  pos, lo, hi);
      return c;
   endfunction

   always @(posedge clock) begin
      rgb_type want;
      if (reset) begin
         color_due.delete();
         map_lo         <= '0;
         map_hi         <= 16'sd1000;
         direct_on      <= 1'b0;
         mismatch_count <= 0;
         waiting_items  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (color_due.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t unexpected item: expected none, got r %0d g %0d b %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
            end else begin
               want = color_due.pop_front();
               if (want.red !== rsp_red || want.green !== rsp_green ||
                   want.blue !== rsp_blue) begin
                  mismatch_count <= mismatch_count + 1;
                  $display("%0t color mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                           $time, want.red, want.green, want.blue,
                           rsp_red, rsp_green, rsp_blue);
               end
            end
         end
         if (req_valid && req_ready) color_due.push_back(expected_color(req_sample));
         waiting_items <= color_due.size();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RANGE_MIN:   map_lo    <= csr_wdata;
               CSR_RANGE_MAX:   map_hi    <= csr_wdata;
               CSR_DIRECT_MODE: direct_on <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ bench/tb_value_to_color_map_top.sv @@
`timescale 1ns / 1ps
module tb_value_to_color_map_top;
   import cmap_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 25;
   localparam int PHASE_ITEMS    = 111;
   localparam int RANDOM_PHASES  = 12;
   localparam int IDLE_PCT       = 37;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic signed [SMP_W-1:0] req_sample  = '0;
   logic                    rsp_ready   = 1'b0;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index   = '0;
   logic [SMP_W-1:0]        csr_wdata   = '0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [CH_W-1:0]         rsp_red;
   logic [CH_W-1:0]         rsp_green;
   logic [CH_W-1:0]         rsp_blue;
   int                      mismatch_count;
   int                      waiting_items;

   bit                      sender_gaps   = 1'b1;
   bit                      receiver_gaps = 1'b1;
   int                      hold_requests = 0;
   int                      quiet_cycles  = 0;
   logic signed [SMP_W-1:0] cur_lo        = '0;
   logic signed [SMP_W-1:0] cur_hi        = 16'sd1000;
   logic                    cur_direct    = 1'b0;

   always #5 clock = ~clock;

   value_to_color_map_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   value_to_color_map_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .waiting_items  (waiting_items)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("value_to_color_map_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int hold_served;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_served + 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= !(receiver_gaps && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SMP_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic signed [SMP_W-1:0] lo,
                               input logic signed [SMP_W-1:0] hi,
                               input logic direct);
      write_reg(CSR_RANGE_MIN, lo);
      write_reg(CSR_SPARE, 16'($urandom));
      write_reg(CSR_RANGE_MAX, hi);
      write_reg(CSR_DIRECT_MODE, {15'($urandom), direct});
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur_lo     = lo;
      cur_hi     = hi;
      cur_direct = direct;
   endtask

   task automatic send_sample(input logic [SMP_W-1:0] smp);
      while (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting_items != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly samples that land inside the table, a quarter raw 16-bit noise
   function automatic logic [SMP_W-1:0] pick_sample();
      int     r;
      int     t;
      longint v;
      r = $urandom_range(0, 99);
      if (r < 25) return 16'($urandom);
      if (r < 40) begin
         case ($urandom_range(0, 3))
            0:       t = 0;
            1:       t = PT_MID_LO;
            2:       t = PT_MID_HI;
            default: t = SCALE_TOP;
         endcase
         t = t + int'($urandom_range(0, 4)) - 2;
      end else begin
         t = int'($urandom_range(0, 1100)) - 50;
      end
      if (cur_direct) v = t;
      else v = longint'(cur_lo) + (longint'(cur_hi) - longint'(cur_lo)) * t / SCALE_TOP;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   task automatic random_config(input int kind);
      logic signed [SMP_W-1:0] lo;
      logic signed [SMP_W-1:0] hi;
      logic                    direct;
      lo     = '0;
      hi     = 16'sd1000;
      direct = 1'b0;
      case (kind)
         0: ;
         1, 2, 3: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
         4: begin
            lo = 16'sh8000;
            hi = 16'sh7FFF;
         end
         5: begin
            lo = 16'sh7FFF;
            hi = 16'sh8000;
         end
         6: begin
            lo = 16'($urandom);
            hi = lo;
         end
         7, 8: begin
            lo     = 16'($urandom);
            hi     = 16'($urandom);
            direct = 1'b1;
         end
         default: begin
            lo = 16'(int'($urandom_range(0, 400)) - 200);
            hi = lo + 16'($urandom_range(1, 20));
         end
      endcase
      apply_config(lo, hi, direct);
   endtask

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset range 0..1000: breakpoints and both sides of them, saturation
      send_sample(16'd0);
      send_sample(16'd400);
      send_sample(16'd401);
      send_sample(16'd600);
      send_sample(16'd601);
      send_sample(16'd1000);
      send_sample(16'd1001);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      finish_phase();

      // zero range
      apply_config(16'sd123, 16'sd123, 1'b0);
      send_sample(16'd123);
      send_sample(16'h8000);
      finish_phase();

      // inverted range
      apply_config(16'sd1000, 16'sd0, 1'b0);
      send_sample(16'd250);
      send_sample(16'd1200);
      finish_phase();

      // widest range
      apply_config(16'sh8000, 16'sh7FFF, 1'b0);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'd0);
      finish_phase();

      // direct index
      apply_config(16'sd0, 16'sd1000, 1'b1);
      send_sample(16'hFFFF);
      send_sample(16'd0);
      send_sample(16'd400);
      send_sample(16'd600);
      send_sample(16'd1000);
      send_sample(16'h7FFF);
      finish_phase();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_config(phase < 10 ? phase : int'($urandom_range(0, 9)));
         sender_gaps   = (phase != 1) && (phase != 3);
         receiver_gaps = (phase != 3);
         if (phase == 1) hold_requests <= hold_requests + 1;
         repeat (PHASE_ITEMS) send_sample(pick_sample());
         finish_phase();
      end

      if (mismatch_count == 0 && waiting_items == 0) begin
         $display("value_to_color_map_top regression: pass");
      end else begin
         $display("value_to_color_map_top regression: fail");
      end
      $finish;
   end

endmodule
